/* sv/sfdtd_pkg.sv */
// Shared types, field layout and fixed-point helpers for the stiff string
// finite-difference step unit. No dependencies.

package sfdtd_pkg;

	// Field widths of the stream beats and the configuration port.
	localparam int DISP_W     = 24;
	localparam int COEF_W     = 32;
	localparam int IDX_W      = 9;
	localparam int NPTS_W     = 9;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Input tdata layout, lowest bit first: point_index, value, read_index.
	localparam int PIDX_LSB   = 0;
	localparam int VALUE_LSB  = PIDX_LSB + IDX_W;
	localparam int RIDX_LSB   = VALUE_LSB + DISP_W;
	localparam int S_FIELDS_W = RIDX_LSB + IDX_W;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_TDATA_W  = ((DISP_W + 7) / 8) * 8;

	// Command codes carried in tuser.
	localparam logic CMD_STEP   = 1'b0;
	localparam logic CMD_EXCITE = 1'b1;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER_NOW  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_NEAR_NOW    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_FAR_NOW     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER_PREV = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_NEAR_PREV   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_POINTS       = 3'd5;
	localparam int NUM_COEFS = 5;

	localparam logic [NPTS_W-1:0] NUM_POINTS_RESET = 9'd64;

	// Grid geometry.
	localparam int MAX_POINTS_DEFAULT = 256;
	localparam int FIRST_NODE         = 2;
	localparam int STENCIL_REACH      = 2;
	localparam int NUM_LEVELS         = 3;
	localparam int CUR_WIN            = 2 * STENCIL_REACH + 1;
	localparam int PRV_WIN            = 4;

	// Cycles between the last sweep read and the last write of a step.
	localparam int DRAIN_CYCLES = 7;
	localparam int DRAIN_W      = 3;

	// Fixed-point formats: displacement Q1.22, coefficient Q4.27.
	localparam int COEF_FRAC = 27;
	localparam int OPND_W    = DISP_W + 1;
	localparam int PROD_W    = OPND_W + COEF_W;
	localparam int TERM_W    = PROD_W - COEF_FRAC;
	localparam int SUM_W     = TERM_W + 3;

	typedef logic signed [DISP_W-1:0] disp_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [OPND_W-1:0] opnd_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [TERM_W-1:0] term_t;
	typedef logic signed [SUM_W-1:0]  sum_t;

	localparam disp_t DISP_MAX   = 24'sh7FFFFF;
	localparam disp_t DISP_MIN   = 24'sh800000;
	localparam prod_t ROUND_HALF = prod_t'(1) << (COEF_FRAC - 1);

	// Rounds a Q7.49 product to Q7.22, ties toward plus infinity.
	function automatic term_t round_term(input prod_t p);
		prod_t r;
		r = p + ROUND_HALF;
		return r[PROD_W-1:COEF_FRAC];
	endfunction

endpackage

/* sv/stiff_string_fdtd_step_unit.sv */
// Top level of the stiff string finite-difference step unit: three level
// memories, the sweep and multiply pipeline and the command sequencer.
// Depends on sfdtd_pkg.

// Usage:
// Commands arrive on the s_axis channel, one beat per command; tuser selects
// step or excite. Every command returns one beat on m_axis with a displacement.
// An excite writes the value into the current and previous levels and
// returns it. A step sweeps nodes 0 to N, with N the effective point count,
// through the current and previous level memories at one node per cycle,
// feeds a seven-stage multiply-accumulate pipeline, writes the next level
// and returns the read_index node of the new level, zero if beyond N. Each
// level memory has a single read port, shared by the sweep and the result read.
// One command is in progress at a time; the next one is accepted as
// soon as the previous result has been moved to the output register, even if
// the receiver has not taken it yet. When the receiver stalls, the result
// stays in the output register and the following result waits in the unit.
// After reset the unit zeroes all three level memories, addresses 0 to
// MAX_POINTS, holding s_axis_tready low; configuration writes are taken at any
// time but must only change registers while no command is in progress.

module stiff_string_fdtd_step_unit #(
	parameter int MAX_POINTS = sfdtd_pkg::MAX_POINTS_DEFAULT
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_axis_tvalid,
	output logic                                  s_axis_tready,
	// point_index [8:0], value [32:9], read_index [41:33], zero fill above
	input  logic [sfdtd_pkg::S_TDATA_W-1:0]       s_axis_tdata,
	// command
	input  logic                                  s_axis_tuser,
	output logic                                  m_axis_tvalid,
	input  logic                                  m_axis_tready,
	// displacement [23:0]
	output logic [sfdtd_pkg::M_TDATA_W-1:0]       m_axis_tdata,
	input  logic                                  cfg_we,
	input  logic [sfdtd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sfdtd_pkg::CFG_DATA_W-1:0]      cfg_data
);

	localparam int AW = $clog2(MAX_POINTS + 1);
	localparam int IW = (AW > sfdtd_pkg::IDX_W) ? AW : sfdtd_pkg::IDX_W;
	localparam logic [AW-1:0] LAST_ADDR     = AW'(MAX_POINTS);
	localparam logic [AW-1:0] COMPUTE_START =
		AW'(sfdtd_pkg::FIRST_NODE + sfdtd_pkg::STENCIL_REACH);
	localparam logic [AW-1:0] REACH         = AW'(sfdtd_pkg::STENCIL_REACH);
	localparam logic [sfdtd_pkg::DRAIN_W-1:0] DRAIN_LAST =
		sfdtd_pkg::DRAIN_W'(sfdtd_pkg::DRAIN_CYCLES - 1);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SWEEP,
		ST_DRAIN,
		ST_RES_RD,
		ST_RES_WAIT,
		ST_OUT
	} state_t;

	// Control and configuration state.
	state_t                           state_q;
	logic [AW-1:0]                    clr_q;
	logic [AW-1:0]                    k_q;
	logic [sfdtd_pkg::DRAIN_W-1:0]    drain_q;
	logic [1:0]                       rot_q;
	logic [IW-1:0]                    ridx_q;
	sfdtd_pkg::disp_t                 res_q;
	logic                             m_tvalid_q;
	sfdtd_pkg::disp_t                 m_tdata_q;
	sfdtd_pkg::coef_t                 coef_q [sfdtd_pkg::NUM_COEFS];
	logic [sfdtd_pkg::NPTS_W-1:0]     num_points_q;

	// Input beat fields.
	logic                             in_cmd;
	logic [sfdtd_pkg::IDX_W-1:0]      in_pidx;
	sfdtd_pkg::disp_t                 in_value;
	logic [sfdtd_pkg::IDX_W-1:0]      in_ridx;
	logic                             s_accept;
	logic [IW-1:0]                    pidx_w;
	logic [IW-1:0]                    n_eff_w;
	logic [AW-1:0]                    n_eff;

	// Level roles and memory ports.
	logic [1:0]                       nxt_sel;
	logic [1:0]                       cur_sel;
	logic [1:0]                       prv_sel;
	logic [1:0]                       rot_next;
	logic [sfdtd_pkg::NUM_LEVELS-1:0] mem_we;
	logic [AW-1:0]                    waddr;
	sfdtd_pkg::disp_t                 wdata;
	logic [AW-1:0]                    raddr;
	sfdtd_pkg::disp_t                 rdata [sfdtd_pkg::NUM_LEVELS];
	logic                             clr_we;
	logic                             exc_we;
	logic                             stp_we;

	// Sweep pipeline.
	logic                             rv_s1;
	logic [AW-1:0]                    k_s1;
	sfdtd_pkg::disp_t                 cw_s2 [sfdtd_pkg::CUR_WIN];
	sfdtd_pkg::disp_t                 pw_s2 [sfdtd_pkg::PRV_WIN];
	logic                             v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [AW-1:0]                    l_s2, l_s3, l_s4, l_s5, l_s6, l_s7;
	sfdtd_pkg::opnd_t                 a_s3 [sfdtd_pkg::NUM_COEFS];
	sfdtd_pkg::prod_t                 p_s4 [sfdtd_pkg::NUM_COEFS];
	sfdtd_pkg::term_t                 t_s5 [sfdtd_pkg::NUM_COEFS];
	sfdtd_pkg::sum_t                  u_s6 [3];
	sfdtd_pkg::sum_t                  s_s7;
	sfdtd_pkg::disp_t                 sat;

	// Unpack the input beat.
	assign in_cmd   = s_axis_tuser;
	assign in_pidx  = s_axis_tdata[sfdtd_pkg::PIDX_LSB +: sfdtd_pkg::IDX_W];
	assign in_value = s_axis_tdata[sfdtd_pkg::VALUE_LSB +: sfdtd_pkg::DISP_W];
	assign in_ridx  = s_axis_tdata[sfdtd_pkg::RIDX_LSB +: sfdtd_pkg::IDX_W];

	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_accept      = s_axis_tvalid && s_axis_tready;
	assign pidx_w        = IW'(in_pidx);

	assign m_axis_tvalid = m_tvalid_q;
	assign m_axis_tdata  = sfdtd_pkg::M_TDATA_W'(m_tdata_q);

	// Effective point count is clamped to MAX_POINTS, the last memory address.
	always_comb begin
		if (IW'(num_points_q) > IW'(MAX_POINTS)) begin
			n_eff_w = IW'(MAX_POINTS);
		end else begin
			n_eff_w = IW'(num_points_q);
		end
	end
	assign n_eff = n_eff_w[AW-1:0];

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < sfdtd_pkg::NUM_COEFS; i++) begin
				coef_q[i] <= '0;
			end
			num_points_q <= sfdtd_pkg::NUM_POINTS_RESET;
		end else if (cfg_we) begin
			if (cfg_index <= sfdtd_pkg::REG_COEF_NEAR_PREV) begin
				coef_q[cfg_index] <= sfdtd_pkg::coef_t'(cfg_data);
			end else if (cfg_index == sfdtd_pkg::REG_NUM_POINTS) begin
				num_points_q <= cfg_data[sfdtd_pkg::NPTS_W-1:0];
			end
		end
	end

	// Role of each level memory: next, current and previous level.
	always_comb begin
		nxt_sel = rot_q;
		unique case (rot_q)
			2'd0: begin
				cur_sel  = 2'd1;
				prv_sel  = 2'd2;
				rot_next = 2'd2;
			end
			2'd1: begin
				cur_sel  = 2'd2;
				prv_sel  = 2'd0;
				rot_next = 2'd0;
			end
			2'd2: begin
				cur_sel  = 2'd0;
				prv_sel  = 2'd1;
				rot_next = 2'd1;
			end
			default: begin
				cur_sel  = 2'd1;
				prv_sel  = 2'd2;
				rot_next = 2'd2;
			end
		endcase
	end

	// Saturate the node sum to the displacement range.
	always_comb begin
		if (s_s7 > sfdtd_pkg::sum_t'(sfdtd_pkg::DISP_MAX)) begin
			sat = sfdtd_pkg::DISP_MAX;
		end else if (s_s7 < sfdtd_pkg::sum_t'(sfdtd_pkg::DISP_MIN)) begin
			sat = sfdtd_pkg::DISP_MIN;
		end else begin
			sat = s_s7[sfdtd_pkg::DISP_W-1:0];
		end
	end

	// Write port: clearing pass, excite, or a finished node of a step.
	always_comb begin
		clr_we = 1'b0;
		exc_we = 1'b0;
		stp_we = 1'b0;
		waddr  = '0;
		wdata  = '0;
		priority if (state_q == ST_CLEAR) begin
			clr_we = 1'b1;
			waddr  = clr_q;
		end else if (s_accept && in_cmd == sfdtd_pkg::CMD_EXCITE && pidx_w <= n_eff_w) begin
			exc_we = 1'b1;
			waddr  = pidx_w[AW-1:0];
			wdata  = in_value;
		end else if (v_s7) begin
			stp_we = 1'b1;
			waddr  = l_s7;
			wdata  = sat;
		end
		for (int g = 0; g < sfdtd_pkg::NUM_LEVELS; g++) begin
			mem_we[g] = clr_we
				|| (exc_we && (2'(g) == cur_sel || 2'(g) == prv_sel))
				|| (stp_we && 2'(g) == nxt_sel);
		end
	end

	// The shared read address walks the sweep, then fetches the result node.
	assign raddr = (state_q == ST_RES_RD) ? ridx_q[AW-1:0] : k_q;

	// Level memories, one write and one registered read per cycle each.
	for (genvar g = 0; g < sfdtd_pkg::NUM_LEVELS; g++) begin : g_level
		sfdtd_pkg::disp_t mem [0:MAX_POINTS];

		always_ff @(posedge clk) begin
			if (mem_we[g]) begin
				mem[waddr] <= wdata;
			end
			rdata[g] <= mem[raddr];
		end
	end

	// Pipeline valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rv_s1 <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
			v_s5  <= 1'b0;
			v_s6  <= 1'b0;
			v_s7  <= 1'b0;
		end else begin
			rv_s1 <= (state_q == ST_SWEEP);
			v_s2  <= rv_s1 && (k_s1 >= COMPUTE_START);
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
		end
	end

	// Sweep datapath: sliding windows, operand sums, products, rounding, sum.
	always_ff @(posedge clk) begin
		k_s1 <= k_q;

		// The newest node enters at the top of each window.
		for (int i = 0; i < sfdtd_pkg::CUR_WIN - 1; i++) begin
			cw_s2[i] <= cw_s2[i+1];
		end
		cw_s2[sfdtd_pkg::CUR_WIN-1] <= rdata[cur_sel];
		for (int i = 0; i < sfdtd_pkg::PRV_WIN - 1; i++) begin
			pw_s2[i] <= pw_s2[i+1];
		end
		pw_s2[sfdtd_pkg::PRV_WIN-1] <= rdata[prv_sel];
		l_s2 <= k_s1 - REACH;

		// Node l sits at window slot 2 of the current level, slot 1 of the previous.
		a_s3[0] <= sfdtd_pkg::opnd_t'(cw_s2[2]);
		a_s3[1] <= sfdtd_pkg::opnd_t'(cw_s2[3]) + sfdtd_pkg::opnd_t'(cw_s2[1]);
		a_s3[2] <= sfdtd_pkg::opnd_t'(cw_s2[4]) + sfdtd_pkg::opnd_t'(cw_s2[0]);
		a_s3[3] <= sfdtd_pkg::opnd_t'(pw_s2[1]);
		a_s3[4] <= sfdtd_pkg::opnd_t'(pw_s2[2]) + sfdtd_pkg::opnd_t'(pw_s2[0]);
		l_s3    <= l_s2;

		for (int i = 0; i < sfdtd_pkg::NUM_COEFS; i++) begin
			p_s4[i] <= sfdtd_pkg::prod_t'(a_s3[i]) * sfdtd_pkg::prod_t'(coef_q[i]);
			t_s5[i] <= sfdtd_pkg::round_term(p_s4[i]);
		end
		l_s4 <= l_s3;
		l_s5 <= l_s4;

		u_s6[0] <= sfdtd_pkg::sum_t'(t_s5[0]) + sfdtd_pkg::sum_t'(t_s5[1]);
		u_s6[1] <= sfdtd_pkg::sum_t'(t_s5[2]) + sfdtd_pkg::sum_t'(t_s5[3]);
		u_s6[2] <= sfdtd_pkg::sum_t'(t_s5[4]);
		l_s6    <= l_s5;

		s_s7 <= u_s6[0] + u_s6[1] + u_s6[2];
		l_s7 <= l_s6;
	end

	// Command sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			k_q        <= '0;
			drain_q    <= '0;
			rot_q      <= '0;
			ridx_q     <= '0;
			res_q      <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_axis_tready && state_q != ST_OUT) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == LAST_ADDR) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (s_accept) begin
						ridx_q <= IW'(in_ridx);
						if (in_cmd == sfdtd_pkg::CMD_EXCITE) begin
							res_q   <= in_value;
							state_q <= ST_OUT;
						end else begin
							k_q     <= '0;
							state_q <= ST_SWEEP;
						end
					end
				end
				ST_SWEEP: begin
					k_q <= k_q + 1'b1;
					if (k_q == n_eff) begin
						drain_q <= DRAIN_LAST;
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (drain_q == '0) begin
						// The new level becomes current from here on.
						rot_q <= rot_next;
						if (ridx_q <= n_eff_w) begin
							state_q <= ST_RES_RD;
						end else begin
							res_q   <= '0;
							state_q <= ST_OUT;
						end
					end else begin
						drain_q <= drain_q - 1'b1;
					end
				end
				ST_RES_RD: begin
					state_q <= ST_RES_WAIT;
				end
				ST_RES_WAIT: begin
					res_q   <= rdata[cur_sel];
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (!m_tvalid_q || m_axis_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= res_q;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// One command at a time: no beat is taken right after another.
	a_one_command: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept |=> !s_axis_tready)
		else $error("input beat accepted while a command is in progress");

	// Node writes of a step land before the result read.
	a_step_write_window: assert property (@(posedge clk) disable iff (!arst_n)
		stp_we |-> (state_q == ST_SWEEP || state_q == ST_DRAIN))
		else $error("step write outside the sweep and drain window");

	// Each step moves the rotation to another valid level assignment.
	a_rotation: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN && drain_q == '0) |=>
			(rot_q != $past(rot_q) && rot_q != 2'd3))
		else $error("level rotation did not advance correctly");

endmodule
